### design/hktr_pkg.sv
// Shared types and constants for the held-key table and HID report block.
// No dependencies; compiled before every other file of the block.
package hktr_pkg;

   localparam int MAX_HELD_KEYS_DEF = 6;
   localparam int REPORT_SLOTS      = 6;
   localparam int SLOT_W            = 3;
   localparam int KEY_W             = 8;
   localparam int MOD_W             = 8;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [MOD_W-1:0] mod_type;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_BUILD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   // Write request from the sequencer to the key table.
   typedef struct packed {
      logic    wr_en;
      key_type wr_data;
   } tab_wr_type;

endpackage

### design/hktr_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on nothing; compiled after hktr_pkg.
interface hktr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] modifier_mask;
   logic [7:0] key_code;

   modport source (output valid, output opcode, output modifier_mask, output key_code,
                   input ready);
   modport sink   (input valid, input opcode, input modifier_mask, input key_code,
                   output ready);
endinterface

interface hktr_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic       table_empty;
   logic [7:0] report_modifiers;
   logic [7:0] report_key0;
   logic [7:0] report_key1;
   logic [7:0] report_key2;
   logic [7:0] report_key3;
   logic [7:0] report_key4;
   logic [7:0] report_key5;

   modport source (output valid, output accepted, output table_empty,
                   output report_modifiers, output report_key0, output report_key1,
                   output report_key2, output report_key3, output report_key4,
                   output report_key5, input ready);
   modport sink   (input valid, input accepted, input table_empty,
                   input report_modifiers, input report_key0, input report_key1,
                   input report_key2, input report_key3, input report_key4,
                   input report_key5, output ready);
endinterface

### design/held_key_table_hid_report.sv
// Held-key table and HID boot keyboard report builder, one response per request.
// Each request walks the table through one shared comparator (release all skips the walk),
// then waits for the output register to be free before its response is written.
// A new item is taken only in idle, once the previous one has written its response;
// a pending response does not block acceptance.
// Reset is synchronous and active high: empty table, no modifiers, no response pending.
module held_key_table_hid_report #(
   parameter int MAX_HELD_KEYS = hktr_pkg::MAX_HELD_KEYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hktr_req_if.sink    req_ch,
   hktr_rsp_if.source  rsp_ch
);
   import hktr_pkg::*;

   localparam int IDX_W = (MAX_HELD_KEYS > 1) ? $clog2(MAX_HELD_KEYS) : 1;
   localparam int CNT_W = $clog2(MAX_HELD_KEYS + 1);
   // Width wide enough to compare counts against the six report slots.
   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   // Sequencer and working registers.
   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   mod_type             mask_ff, mask_in;
   key_type             code_ff, code_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                found_ff, found_in;

   // Architectural state: modifiers and fill count of the key table.
   mod_type             mods_ff, mods_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // Report key slots gathered during the walk of a build request.
   key_type             rpt_ff [REPORT_SLOTS];
   key_type             rpt_in [REPORT_SLOTS];

   // Output register of the response channel.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic                rsp_empty_ff, rsp_empty_in;
   mod_type             rsp_mods_ff, rsp_mods_in;
   key_type             rsp_key_ff [REPORT_SLOTS];
   key_type             rsp_key_in [REPORT_SLOTS];

   // Key table ports.
   logic [IDX_W-1:0]    rd_addr;
   key_type             rd_data;
   logic [IDX_W-1:0]    wr_addr;
   tab_wr_type          tab_wr;

   // Shared compare unit and helpers.
   logic                hit;
   logic [CNT_W-1:0]    idx_prev;
   logic [CMP_W-1:0]    idx_x;
   logic [CMP_W-1:0]    cnt_x;
   logic                add_new;
   logic                table_full;
   logic                rpt_insert;
   logic                out_free;

   hktr_keytab #(
      .MAX_HELD_KEYS (MAX_HELD_KEYS)
   ) u_keytab (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr      (tab_wr)
   );

   // The table is walked one entry per cycle at the scan index.
   assign rd_addr    = idx_ff[IDX_W-1:0];
   assign hit        = (rd_data == code_ff);
   assign idx_prev   = idx_ff - CNT_W'(1);
   assign idx_x      = CMP_W'(idx_ff);
   assign cnt_x      = CMP_W'(count_ff);
   assign add_new    = (code_ff != '0) && !found_ff;
   assign table_full = (count_ff == CNT_W'(MAX_HELD_KEYS));
   // The given key joins the report only when it is new and a slot is still free.
   assign rpt_insert = add_new && (cnt_x < CMP_W'(REPORT_SLOTS));
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.accepted         = rsp_acc_ff;
   assign rsp_ch.table_empty      = rsp_empty_ff;
   assign rsp_ch.report_modifiers = rsp_mods_ff;
   assign rsp_ch.report_key0      = rsp_key_ff[0];
   assign rsp_ch.report_key1      = rsp_key_ff[1];
   assign rsp_ch.report_key2      = rsp_key_ff[2];
   assign rsp_ch.report_key3      = rsp_key_ff[3];
   assign rsp_ch.report_key4      = rsp_key_ff[4];
   assign rsp_ch.report_key5      = rsp_key_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mods_ff      <= mods_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      mask_ff      <= mask_in;
      code_ff      <= code_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      rpt_ff       <= rpt_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_mods_ff  <= rsp_mods_in;
      rsp_key_ff   <= rsp_key_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mask_in      = mask_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      mods_in      = mods_ff;
      count_in     = count_ff;
      rpt_in       = rpt_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_mods_in  = rsp_mods_ff;
      rsp_key_in   = rsp_key_ff;
      wr_addr      = '0;
      tab_wr       = '0;

      // The downstream side drains the output register independently.
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = op_type'(req_ch.opcode);
               mask_in  = req_ch.modifier_mask;
               code_in  = req_ch.key_code;
               idx_in   = '0;
               found_in = 1'b0;
               for (int k = 0; k < REPORT_SLOTS; k++) begin
                  rpt_in[k] = '0;
               end
               state_in = (op_type'(req_ch.opcode) == OP_CLEAR) ? ST_FINISH : ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               // Once the removed key is found, each later entry moves down one place.
               if ((op_ff == OP_REMOVE) && found_ff) begin
                  wr_addr        = idx_prev[IDX_W-1:0];
                  tab_wr.wr_en   = 1'b1;
                  tab_wr.wr_data = rd_data;
               end
               if (hit) begin
                  found_in = 1'b1;
               end
               if ((op_ff == OP_BUILD) && (idx_x < CMP_W'(REPORT_SLOTS))) begin
                  rpt_in[idx_x[SLOT_W-1:0]] = rd_data;
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_acc_in  = 1'b1;
               rsp_mods_in = '0;
               for (int k = 0; k < REPORT_SLOTS; k++) begin
                  rsp_key_in[k] = '0;
               end

               case (op_ff)
                  OP_ADD: begin
                     mods_in = mods_ff | mask_ff;
                     if (add_new) begin
                        if (table_full) begin
                           rsp_acc_in = 1'b0;
                        end else begin
                           wr_addr        = count_ff[IDX_W-1:0];
                           tab_wr.wr_en   = 1'b1;
                           tab_wr.wr_data = code_ff;
                           count_in       = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  OP_REMOVE: begin
                     mods_in = mods_ff & ~mask_ff;
                     if (found_ff) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_CLEAR: begin
                     mods_in  = '0;
                     count_in = '0;
                  end
                  OP_BUILD: begin
                     rsp_mods_in = mods_ff | mask_ff;
                     for (int k = 0; k < REPORT_SLOTS; k++) begin
                        if (rpt_insert && (cnt_x == CMP_W'(k))) begin
                           rsp_key_in[k] = code_ff;
                        end else begin
                           rsp_key_in[k] = rpt_ff[k];
                        end
                     end
                  end
                  default: begin
                     mods_in = mods_ff;
                  end
               endcase

               rsp_empty_in = (mods_in == '0) && (count_in == '0);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/hktr_keytab.sv
// Held keycode table: one read port at the scan index, one write port.
// Depends on hktr_pkg.
module hktr_keytab #(
   parameter int MAX_HELD_KEYS = hktr_pkg::MAX_HELD_KEYS_DEF,
   localparam int IDX_W = (MAX_HELD_KEYS > 1) ? $clog2(MAX_HELD_KEYS) : 1
) (
   input  logic                   clock,
   input  logic [IDX_W-1:0]       rd_addr,
   output hktr_pkg::key_type      rd_data,
   input  logic [IDX_W-1:0]       wr_addr,
   input  hktr_pkg::tab_wr_type   wr
);
   import hktr_pkg::*;

   key_type keys_ff [MAX_HELD_KEYS];

   // Entries at or beyond the fill count are never read, so no reset.
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         keys_ff[wr_addr] <= wr.wr_data;
      end
   end

   assign rd_data = keys_ff[rd_addr];

endmodule

### test/tb_top.sv
// Self-checking testbench for the held-key table and HID boot report block.
// Depends on hktr_pkg, the hktr_req_if/hktr_rsp_if interfaces and the block's top level.
`timescale 1ns / 1ps

module tb_top;
   import hktr_pkg::*;

   localparam int TABLE_DEPTH      = MAX_HELD_KEYS_DEF;
   localparam int RANDOM_ITEMS     = 425;
   localparam int EPISODE_LEN      = 30;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 24;

   // One response item as the block should present it. Slot 0 of keys is report byte 2.
   typedef struct packed {
      logic                          accepted;
      logic                          table_empty;
      mod_type                       modifiers;
      key_type [REPORT_SLOTS-1:0]    keys;
   } report_result_type;

   // The scoreboard keeps its own copy of the held modifiers and the key table. Every
   // accepted request advances that copy and queues the response it must produce; every
   // accepted response is compared field by field against the oldest queued one.
   class report_scoreboard;
      mod_type           held_mods;
      int unsigned       held_len;
      key_type           held_tab [TABLE_DEPTH];
      report_result_type expected_reports [$];
      int unsigned       failures;
      int unsigned       checked;
      int unsigned       full_rejects;

      function new();
         failures     = 0;
         checked      = 0;
         full_rejects = 0;
         clear_state();
      endfunction

      function void clear_state();
         held_mods = '0;
         held_len  = 0;
         foreach (held_tab[i]) held_tab[i] = '0;
      endfunction

      function bit key_held(key_type k);
         for (int i = 0; i < held_len; i++) begin
            if (held_tab[i] == k) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
      endfunction

      function int unsigned pending();
         return expected_reports.size();
      endfunction

      function void note_request(op_type op, mod_type m, key_type k);
         report_result_type exp_r;
         int unsigned       slot;
         exp_r          = '0;
         exp_r.accepted = 1'b1;
         case (op)
            OP_ADD: begin
               held_mods = held_mods | m;
               if (k != '0 && !key_held(k)) begin
                  if (held_len >= TABLE_DEPTH) begin
                     exp_r.accepted = 1'b0;
                     full_rejects++;
                  end else begin
                     held_tab[held_len] = k;
                     held_len++;
                  end
               end
            end
            OP_REMOVE: begin
               held_mods = held_mods & ~m;
               if (k != '0) begin
                  // Close the gap so the table stays packed from the bottom.
                  for (int i = 0; i < held_len; i++) begin
                     if (held_tab[i] == k) begin
                        for (int j = i; j + 1 < held_len; j++) held_tab[j] = held_tab[j + 1];
                        held_len--;
                        held_tab[held_len] = '0;
                        break;
                     end
                  end
               end
            end
            OP_CLEAR: clear_state();
            default: begin
               exp_r.modifiers = held_mods | m;
               slot = 0;
               for (int i = 0; i < held_len && slot < REPORT_SLOTS; i++) begin
                  exp_r.keys[slot] = held_tab[i];
                  slot++;
               end
               if (k != '0 && slot < REPORT_SLOTS && !key_held(k)) exp_r.keys[slot] = k;
            end
         endcase
         exp_r.table_empty = (held_mods == '0 && held_len == 0);
         expected_reports.push_back(exp_r);
      endfunction

      function void check_response(report_result_type got);
         report_result_type want;
         if (expected_reports.size() == 0) begin
            flag($sformatf("response with nothing expected (%h)", got));
            return;
         end
         want = expected_reports.pop_front();
         checked++;
         if (got.accepted !== want.accepted)
            flag($sformatf("accepted expected %0b got %0b", want.accepted, got.accepted));
         if (got.table_empty !== want.table_empty)
            flag($sformatf("table_empty expected %0b got %0b", want.table_empty,
                           got.table_empty));
         if (got.modifiers !== want.modifiers)
            flag($sformatf("report_modifiers expected %02h got %02h", want.modifiers,
                           got.modifiers));
         for (int s = 0; s < REPORT_SLOTS; s++) begin
            if (got.keys[s] !== want.keys[s])
               flag($sformatf("report_key%0d expected %02h got %02h", s, want.keys[s],
                              got.keys[s]));
         end
      endfunction
   endclass

   // Clock and reset. Reset starts asserted so every process sees it from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   hktr_req_if req_if ();
   hktr_rsp_if rsp_if ();

   held_key_table_hid_report u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   report_scoreboard board;
   int unsigned      op_seen [4];
   key_type          key_pool [8];

   // Raised by the stimulus once; the response side then refuses items for a long
   // stretch while the request side keeps offering, so the block backs up.
   bit long_hold_req = 1'b0;

   // Watch both channels. Everything here reads the values that stood before the
   // edge, so the order of processes within the time step does not matter.
   always @(posedge clock) begin : channel_watch
      report_result_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            board.note_request(op_type'(req_if.opcode), req_if.modifier_mask,
                               req_if.key_code);
            op_seen[req_if.opcode]++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.accepted    = rsp_if.accepted;
            got.table_empty = rsp_if.table_empty;
            got.modifiers   = rsp_if.report_modifiers;
            got.keys[0]     = rsp_if.report_key0;
            got.keys[1]     = rsp_if.report_key1;
            got.keys[2]     = rsp_if.report_key2;
            got.keys[3]     = rsp_if.report_key3;
            got.keys[4]     = rsp_if.report_key4;
            got.keys[5]     = rsp_if.report_key5;
            board.check_response(got);
         end
      end
   end

   // Response pacing. The ready pattern rotates through always ready, coin-flip ready,
   // mostly stalled and a fixed five-of-eight duty, so stalls land on every phase of the
   // block's table walk. The long hold is counted here.
   initial begin : response_pacing
      int unsigned cyc;
      cyc = 0;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
            rsp_if.ready <= 1'b1;
         end else begin
            cyc++;
            case ((cyc / 64) % 4)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ((cyc % 8) < 5);
            endcase
         end
      end
   end

   // Offer one request item and return at the edge where it is taken.
   task automatic send_item(op_type op, mod_type m, key_type k);
      req_if.valid         <= 1'b1;
      req_if.opcode        <= op;
      req_if.modifier_mask <= m;
      req_if.key_code      <= k;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic sender_idle(int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop offering and wait until every queued expectation has been met. The first
   // edge lets the watcher record an item taken at the edge we were called on.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Hand-picked items: empty reports, modifier-only adds and removes, filling the table,
   // an add that finds it full, a duplicate add while full, a report key with no slot
   // left, removal from the middle, first and last positions, removal of a key that is
   // not held, a duplicate report key, release all with busy fields, and the extreme
   // field values.
   task automatic run_directed();
      send_item(OP_BUILD,  8'h00, 8'h00);
      send_item(OP_ADD,    8'hFF, 8'h00);
      send_item(OP_BUILD,  8'h00, 8'h00);
      send_item(OP_REMOVE, 8'hFF, 8'h00);
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_item(OP_ADD, mod_type'(1 << i), key_type'(8'h04 + i));
      send_item(OP_ADD,    8'h80, 8'h0A);
      send_item(OP_ADD,    8'h00, 8'h04);
      send_item(OP_BUILD,  8'h00, 8'h0B);
      send_item(OP_REMOVE, 8'h00, 8'h06);
      send_item(OP_REMOVE, 8'h00, 8'h77);
      send_item(OP_BUILD,  8'h40, 8'h05);
      send_item(OP_BUILD,  8'h00, 8'hFF);
      send_item(OP_REMOVE, 8'h00, 8'h04);
      send_item(OP_REMOVE, 8'h00, 8'h09);
      send_item(OP_CLEAR,  8'hFF, 8'hFF);
      send_item(OP_ADD,    8'hFF, 8'hFF);
      send_item(OP_BUILD,  8'hFF, 8'hFF);
      send_item(OP_REMOVE, 8'h00, 8'hFF);
      send_item(OP_BUILD,  8'h55, 8'h80);
      send_item(OP_CLEAR,  8'h00, 8'h00);
   endtask

   initial begin : stimulus
      int unsigned burst_left;
      int unsigned pick;
      op_type      op;
      mod_type     m;
      key_type     k;

      board = new();
      foreach (op_seen[i]) op_seen[i] = 0;
      req_if.valid         <= 1'b0;
      req_if.opcode        <= OP_ADD;
      req_if.modifier_mask <= '0;
      req_if.key_code      <= '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      // Random part. It runs in episodes that each draw a small pool of eight keys; with
      // more pool keys than table entries, adds keep hitting duplicates and a full table,
      // and removes mostly find their key. A few picks are zero or anything at all.
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % EPISODE_LEN == 0) begin
            foreach (key_pool[i]) key_pool[i] = key_type'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 1) send_item(OP_CLEAR, mod_type'($urandom_range(0, 255)),
                                                     key_type'($urandom_range(0, 255)));
         end
         if (n == 120) long_hold_req = 1'b1;
         if (n == 300) wait_drained();

         // Requests come in bursts; most bursts are followed by a short gap.
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) sender_idle($urandom_range(1, 12));
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;

         pick = $urandom_range(0, 99);
         if (pick < 45)      op = OP_ADD;
         else if (pick < 70) op = OP_REMOVE;
         else if (pick < 94) op = OP_BUILD;
         else                op = OP_CLEAR;

         case ($urandom_range(0, 3))
            0:       m = '0;
            1:       m = mod_type'(1 << $urandom_range(0, 7));
            default: m = mod_type'($urandom_range(0, 255));
         endcase

         pick = $urandom_range(0, 9);
         if (pick == 0)      k = '0;
         else if (pick == 1) k = key_type'($urandom_range(0, 255));
         else                k = key_pool[$urandom_range(0, 7)];

         send_item(op, m, k);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d add, %0d remove, %0d release all, %0d report.",
               op_seen[OP_ADD] + op_seen[OP_REMOVE] + op_seen[OP_CLEAR] + op_seen[OP_BUILD],
               op_seen[OP_ADD], op_seen[OP_REMOVE], op_seen[OP_CLEAR], op_seen[OP_BUILD]);
      $display("%0d responses checked, %0d adds refused on a full table, %0d mismatches.",
               board.checked, board.full_rejects, board.failures);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("held_key_table_hid_report verification clean");
      end else begin
         $display("held_key_table_hid_report verification failed");
      end
      $finish;
   end

   // Watchdog. A correct run needs well under a tenth of this.
   initial begin : watchdog
      #2_000_000;
      $display("Timed out with %0d responses still expected.", board.pending());
      $display("held_key_table_hid_report verification failed");
      $finish;
   end

endmodule
